// File: rtl/fprsc_pkg.sv
// Shared constants and types for the framed packet receiver with sum check.
`default_nettype none

package fprsc_pkg;

  localparam int unsigned TickCounterWidth = 16;
  localparam int unsigned TimeoutWidth     = 16;
  localparam int unsigned CfgDataWidth     = 16;
  localparam int unsigned CfgAddrWidth     = 2;

  localparam logic [7:0]              ResetDeviceId    = 8'h30;
  localparam logic [7:0]              ResetStartMarker = 8'hFF;
  localparam logic [TimeoutWidth-1:0] ResetTimeout     = TimeoutWidth'(1000);

  // Register indexes on the configuration port
  localparam logic [CfgAddrWidth-1:0] CfgDeviceId    = CfgAddrWidth'(0);
  localparam logic [CfgAddrWidth-1:0] CfgStartMarker = CfgAddrWidth'(1);
  localparam logic [CfgAddrWidth-1:0] CfgTimeout     = CfgAddrWidth'(2);

  // Action codes carried in tuser on the input side
  localparam logic ActByte = 1'b0;
  localparam logic ActTick = 1'b1;

  typedef struct packed {
    logic       link_online;
    logic [7:0] data_two;
    logic [7:0] data_one;
    logic [7:0] command;
    logic       frame_bad;
    logic       frame_ok;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/framed_packet_receiver_sum_check_unit.sv
// Top level: seven-byte framed packet receiver with additive checksum and link timeout.
`default_nettype none

// Takes one beat per cycle (a received byte or a millisecond tick) and returns exactly one
// result beat for each. Each input beat is processed in the cycle it is accepted: the frame
// position, running 8-bit sum, captures and tick counter update at the accepting edge, and the
// result is registered at that same edge, in the output slot or, while it stalls, the skid slot.
// A second output slot absorbs one beat while the downstream side stalls, so input is accepted
// back to back until both slots fill.
// Frame: start marker, device id, command, data one, data two, stop (unchecked), checksum
// equal to the 8-bit sum of the first six bytes. Configuration writes take effect at once and
// must be issued only while no beat is in flight.
module framed_packet_receiver_sum_check_unit
  import fprsc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // configuration write port
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i,
  // input stream
  input  wire logic                    s_axis_tvalid_i,
  output      logic                    s_axis_tready_o,
  input  wire logic [7:0]              s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic                    s_axis_tuser_i,   // [0] action
  // output stream
  output      logic                    m_axis_tvalid_o,
  input  wire logic                    m_axis_tready_i,
  output      logic [31:0]             m_axis_tdata_o,   // [7:0] command, [15:8] data_one,
                                                         // [23:16] data_two, [24] link_online
  output      logic [1:0]              m_axis_tuser_o    // [0] frame_ok, [1] frame_bad
);

  typedef enum logic [2:0] {
    PosHunt  = 3'd0,
    PosId    = 3'd1,
    PosCmd   = 3'd2,
    PosData1 = 3'd3,
    PosData2 = 3'd4,
    PosStop  = 3'd5,
    PosCsum  = 3'd6
  } pos_e;

  localparam int unsigned CmpWidth =
    (TickCounterWidth > TimeoutWidth) ? TickCounterWidth : TimeoutWidth;
  localparam logic [TickCounterWidth-1:0] TickMax = '1;

  // configuration
  logic [7:0]              device_id_q, start_marker_q;
  logic [TimeoutWidth-1:0] timeout_q;

  // receiver state
  pos_e                        pos_q, pos_d;
  logic [7:0]                  sum_q, sum_d;
  logic [7:0]                  cap_cmd_q, cap_cmd_d, cap_d1_q, cap_d1_d, cap_d2_q, cap_d2_d;
  logic [7:0]                  held_cmd_q, held_cmd_d, held_d1_q, held_d1_d;
  logic [7:0]                  held_d2_q, held_d2_d;
  logic [TickCounterWidth-1:0] ticks_q, ticks_d;
  logic                        online_q, online_d;
  logic                        ok_d, bad_d;

  // output slots
  result_t out_q, skid_q, res;
  logic    out_valid_q, skid_valid_q;
  logic    in_fire, out_fire;

  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire        = out_valid_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q    <= ResetDeviceId;
      start_marker_q <= ResetStartMarker;
      timeout_q      <= ResetTimeout;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgDeviceId:    device_id_q    <= cfg_data_i[7:0];
        CfgStartMarker: start_marker_q <= cfg_data_i[7:0];
        CfgTimeout:     timeout_q      <= cfg_data_i[TimeoutWidth-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    logic [TickCounterWidth-1:0] tick_inc;
    logic [7:0]                  b;
    pos_d      = pos_q;
    sum_d      = sum_q;
    cap_cmd_d  = cap_cmd_q;
    cap_d1_d   = cap_d1_q;
    cap_d2_d   = cap_d2_q;
    held_cmd_d = held_cmd_q;
    held_d1_d  = held_d1_q;
    held_d2_d  = held_d2_q;
    ticks_d    = ticks_q;
    online_d   = online_q;
    ok_d       = 1'b0;
    bad_d      = 1'b0;
    b          = s_axis_tdata_i;
    tick_inc   = (ticks_q == TickMax) ? ticks_q : ticks_q + 1'b1;

    if (s_axis_tuser_i == ActTick) begin
      // saturating count; the frame in progress is left alone
      ticks_d = tick_inc;
      if (CmpWidth'(tick_inc) > CmpWidth'(timeout_q)) begin
        online_d = 1'b0;
      end
    end else begin
      case (pos_q)
        PosId: begin
          // wrong id drops the frame without rechecking it as a start
          if (b == device_id_q) begin
            sum_d = sum_q + b;
            pos_d = PosCmd;
          end else begin
            pos_d = PosHunt;
          end
        end
        PosCmd: begin
          cap_cmd_d = b;
          sum_d     = sum_q + b;
          pos_d     = PosData1;
        end
        PosData1: begin
          cap_d1_d = b;
          sum_d    = sum_q + b;
          pos_d    = PosData2;
        end
        PosData2: begin
          cap_d2_d = b;
          sum_d    = sum_q + b;
          pos_d    = PosStop;
        end
        PosStop: begin
          sum_d = sum_q + b;
          pos_d = PosCsum;
        end
        PosCsum: begin
          if (b == sum_q) begin
            held_cmd_d = cap_cmd_q;
            held_d1_d  = cap_d1_q;
            held_d2_d  = cap_d2_q;
            online_d   = 1'b1;
            ticks_d    = '0;
            ok_d       = 1'b1;
          end else begin
            held_cmd_d = '0;
            held_d1_d  = '0;
            held_d2_d  = '0;
            bad_d      = 1'b1;
          end
          pos_d = PosHunt;
        end
        default: begin
          if (b == start_marker_q) begin
            sum_d = b;
            pos_d = PosId;
          end else begin
            pos_d = PosHunt;
          end
        end
      endcase
    end
  end

  always_comb begin
    res.frame_ok    = ok_d;
    res.frame_bad   = bad_d;
    res.command     = held_cmd_d;
    res.data_one    = held_d1_d;
    res.data_two    = held_d2_d;
    res.link_online = online_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= PosHunt;
      sum_q      <= '0;
      cap_cmd_q  <= '0;
      cap_d1_q   <= '0;
      cap_d2_q   <= '0;
      held_cmd_q <= '0;
      held_d1_q  <= '0;
      held_d2_q  <= '0;
      ticks_q    <= '0;
      online_q   <= 1'b0;
    end else if (in_fire) begin
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      cap_cmd_q  <= cap_cmd_d;
      cap_d1_q   <= cap_d1_d;
      cap_d2_q   <= cap_d2_d;
      held_cmd_q <= held_cmd_d;
      held_d1_q  <= held_d1_d;
      held_d2_q  <= held_d2_d;
      ticks_q    <= ticks_d;
      online_q   <= online_d;
    end
  end

  // output register plus one skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = {out_q.frame_bad, out_q.frame_ok};
  assign m_axis_tdata_o  = {7'b0, out_q.link_online, out_q.data_two, out_q.data_one,
                            out_q.command};

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds a beat while the output slot is empty");

  a_ok_bad_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.frame_ok && out_q.frame_bad))
    else $error("result flags both good and bad frame");

  a_ok_sets_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_ok) |-> out_q.link_online)
    else $error("good frame reported with link offline");

  a_tick_clears_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tuser_i == ActTick) |-> (!ok_d && !bad_d && pos_d == pos_q))
    else $error("tick beat disturbed the frame in progress");
`endif

endmodule

`default_nettype wire

// File: tb/framed_packet_receiver_sum_check_unit_tb.sv
// Testbench for the framed packet receiver: directed and random beats against a predictor.
`default_nettype none

module framed_packet_receiver_sum_check_unit_tb
  import fprsc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned HoldCycles = 60;

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    cfg_we_i        = 1'b0;
  logic [CfgAddrWidth-1:0] cfg_addr_i      = CfgDeviceId;
  logic [CfgDataWidth-1:0] cfg_data_i      = '0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [7:0]              s_axis_tdata_i  = 8'h00;
  logic                    s_axis_tuser_i  = ActByte;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [31:0]             m_axis_tdata_o;
  logic [1:0]              m_axis_tuser_o;

  framed_packet_receiver_sum_check_unit dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  always #10 clk_i = ~clk_i;

  // Register copies seen by the predictor
  logic [7:0]              reg_dev_id  = ResetDeviceId;
  logic [7:0]              reg_marker  = ResetStartMarker;
  logic [TimeoutWidth-1:0] reg_timeout = ResetTimeout;

  // Receiver state as the predictor tracks it; position 0 hunts, 1..6 is the next byte
  logic [2:0]                  rx_pos     = '0;
  logic [7:0]                  rx_sum     = '0;
  logic [7:0]                  cap_cmd    = '0;
  logic [7:0]                  cap_d1     = '0;
  logic [7:0]                  cap_d2     = '0;
  logic [7:0]                  held_cmd   = '0;
  logic [7:0]                  held_d1    = '0;
  logic [7:0]                  held_d2    = '0;
  logic [TickCounterWidth-1:0] tick_count = '0;
  logic                        link_up    = 1'b0;

  result_t frame_reports [$];

  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned beats_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_active    = 1'b0;
  event        begin_hold;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("framed_packet_receiver_sum_check_unit_tb: errors");
      $finish;
    end
  end

  // Long receiver hold-off, timed here so the sender keeps pushing meanwhile
  always begin
    @(begin_hold);
    hold_active = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_active = 1'b0;
  end

  // Advance the predictor by one accepted beat and queue the report it yields
  task automatic track_frame(input logic act, input logic [7:0] b);
    result_t r;
    r = '0;
    if (act == ActTick) begin
      if (tick_count != '1) tick_count = tick_count + 1'b1;
      if (32'(tick_count) > 32'(reg_timeout)) link_up = 1'b0;
    end else begin
      case (rx_pos)
        3'd1: begin
          if (b == reg_dev_id) begin
            rx_sum = rx_sum + b;
            rx_pos = 3'd2;
          end else begin
            rx_pos = 3'd0;
          end
        end
        3'd2: begin
          cap_cmd = b;
          rx_sum  = rx_sum + b;
          rx_pos  = 3'd3;
        end
        3'd3: begin
          cap_d1 = b;
          rx_sum = rx_sum + b;
          rx_pos = 3'd4;
        end
        3'd4: begin
          cap_d2 = b;
          rx_sum = rx_sum + b;
          rx_pos = 3'd5;
        end
        3'd5: begin
          // stop byte joins the sum unchecked
          rx_sum = rx_sum + b;
          rx_pos = 3'd6;
        end
        3'd6: begin
          if (b == rx_sum) begin
            held_cmd   = cap_cmd;
            held_d1    = cap_d1;
            held_d2    = cap_d2;
            link_up    = 1'b1;
            tick_count = '0;
            r.frame_ok = 1'b1;
          end else begin
            held_cmd    = '0;
            held_d1     = '0;
            held_d2     = '0;
            r.frame_bad = 1'b1;
          end
          rx_pos = 3'd0;
        end
        default: begin
          if (b == reg_marker) begin
            rx_sum = b;
            rx_pos = 3'd1;
          end else begin
            rx_pos = 3'd0;
          end
        end
      endcase
    end
    r.command     = held_cmd;
    r.data_one    = held_d1;
    r.data_two    = held_d2;
    r.link_online = link_up;
    frame_reports.push_back(r);
  endtask

  // Receiver side: check each report beat, then pick the next ready value
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.frame_ok    = m_axis_tuser_o[0];
      got.frame_bad   = m_axis_tuser_o[1];
      got.command     = m_axis_tdata_o[7:0];
      got.data_one    = m_axis_tdata_o[15:8];
      got.data_two    = m_axis_tdata_o[23:16];
      got.link_online = m_axis_tdata_o[24];
      if (frame_reports.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected report beat: %p", got);
      end else begin
        want = frame_reports.pop_front();
        if (got.frame_ok !== want.frame_ok || got.frame_bad !== want.frame_bad ||
            got.command !== want.command || got.data_one !== want.data_one ||
            got.data_two !== want.data_two || got.link_online !== want.link_online) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("report mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if (hold_active) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one beat, idling first at random, and hold it until accepted
  task automatic send_beat(input logic act, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    track_frame(act, b);
    beats_sent = beats_sent + 1;
  endtask

  // Stop offering, wait until every report is back, then let the pipe settle
  task automatic wait_results_in();
    s_axis_tvalid_i <= 1'b0;
    while (frame_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [7:0] id, input logic [7:0] marker,
                          input logic [TimeoutWidth-1:0] tmo);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= CfgDeviceId;
    cfg_data_i <= CfgDataWidth'(id);
    @(posedge clk_i);
    reg_dev_id = id;
    cfg_addr_i <= CfgStartMarker;
    cfg_data_i <= CfgDataWidth'(marker);
    @(posedge clk_i);
    reg_marker = marker;
    cfg_addr_i <= CfgTimeout;
    cfg_data_i <= CfgDataWidth'(tmo);
    @(posedge clk_i);
    reg_timeout = tmo;
    cfg_we_i <= 1'b0;
  endtask

  // Send the first nbytes of a frame under the current registers, ticks mixed in between
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] d1, input logic [7:0] d2,
                            input logic [7:0] stop_b, input bit id_ok, input bit sum_ok,
                            input int nbytes, input int tick_pct);
    logic [7:0] fb [7];
    logic [7:0] total;
    fb[0] = reg_marker;
    fb[1] = id_ok ? reg_dev_id : reg_dev_id ^ 8'($urandom_range(1, 255));
    fb[2] = cmd;
    fb[3] = d1;
    fb[4] = d2;
    fb[5] = stop_b;
    total = fb[0] + fb[1] + fb[2] + fb[3] + fb[4] + fb[5];
    fb[6] = sum_ok ? total : total ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < nbytes; i++) begin
      if (i > 0 && $urandom_range(99) < tick_pct) send_beat(ActTick, 8'($urandom));
      send_beat(ActByte, fb[i]);
    end
  endtask

  task automatic send_any_frame(input bit id_ok, input bit sum_ok, input int nbytes,
                                input int tick_pct);
    send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), id_ok, sum_ok,
               nbytes, tick_pct);
  endtask

  // Reset registers: noise while hunting, a tick carrying the marker, extreme payloads
  task automatic test_reset_config();
    send_beat(ActByte, 8'h00);
    send_beat(ActByte, 8'h7F);
    send_beat(ActTick, 8'hFF);
    send_beat(ActByte, ResetDeviceId);
    send_frame(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1, 7, 0);
    send_frame(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1, 7, 0);
  endtask

  // A marker in the id slot abandons the frame and is not taken as a new start
  task automatic test_wrong_id();
    send_beat(ActByte, reg_marker);
    send_beat(ActByte, reg_marker);
    send_beat(ActByte, reg_dev_id);
    send_beat(ActByte, 8'h11);
    send_beat(ActByte, 8'h22);
    send_beat(ActByte, 8'h33);
    send_beat(ActByte, 8'h44);
    send_beat(ActByte, 8'(reg_marker + reg_dev_id + 8'h11 + 8'h22 + 8'h33 + 8'h44));
    send_frame(8'h5A, 8'hA5, 8'h3C, 8'hC3, 1'b0, 1'b1, 7, 0);
  endtask

  // Bad sum clears the held packet but leaves the link state alone
  task automatic test_bad_checksum();
    send_frame(8'h12, 8'h34, 8'h56, 8'h78, 1'b1, 1'b1, 7, 0);
    send_frame(8'h9A, 8'hBC, 8'hDE, 8'hF0, 1'b1, 1'b0, 7, 0);
    send_frame(8'h01, 8'h02, 8'h03, 8'h04, 1'b1, 1'b1, 7, 100);
  endtask

  // Timeout of one and of zero, and a bad frame while offline
  task automatic test_timeout_edges();
    wait_results_in();
    set_regs(reg_dev_id, reg_marker, TimeoutWidth'(1));
    send_any_frame(1'b1, 1'b1, 7, 0);
    send_beat(ActTick, 8'h00);
    send_beat(ActTick, 8'h00);
    send_any_frame(1'b1, 1'b0, 7, 0);
    wait_results_in();
    set_regs(reg_dev_id, reg_marker, TimeoutWidth'(0));
    send_any_frame(1'b1, 1'b1, 7, 0);
    send_beat(ActTick, 8'hFF);
    send_beat(ActTick, 8'h00);
  endtask

  // Timeouts at the top of the range keep the link up across a run of ticks
  task automatic test_large_timeout();
    wait_results_in();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_regs(ResetDeviceId, ResetStartMarker, TimeoutWidth'({TimeoutWidth{1'b1}} - 1));
    send_any_frame(1'b1, 1'b1, 7, 0);
    repeat (40) send_beat(ActTick, 8'($urandom));
    wait_results_in();
    set_regs(ResetDeviceId, ResetStartMarker, {TimeoutWidth{1'b1}});
    send_any_frame(1'b1, 1'b1, 7, 0);
    repeat (40) send_beat(ActTick, 8'($urandom));
  endtask

  // Hold the receiver off while beats keep coming, then let everything drain
  task automatic test_backpressure();
    wait_results_in();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_regs(8'h5C, 8'hA7, TimeoutWidth'(3));
    -> begin_hold;
    send_any_frame(1'b1, 1'b1, 7, 30);
    repeat (6) send_beat(ActTick, 8'($urandom));
    send_any_frame(1'b1, 1'b1, 7, 30);
    send_any_frame(1'b1, 1'b0, 7, 0);
    wait_results_in();
    send_any_frame(1'b1, 1'b1, 7, 0);
  endtask

  // Mostly well-formed frames, with broken frames, tick bursts and line noise
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input logic [7:0] id, input logic [7:0] marker,
                                     input logic [TimeoutWidth-1:0] tmo, input int n_beats);
    int unsigned stop_at;
    int unsigned pick;
    wait_results_in();
    set_regs(id, marker, tmo);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_any_frame($urandom_range(9) != 0, $urandom_range(5) != 0, 7, 15);
      end else if (pick < 75) begin
        send_any_frame(1'b1, 1'b1, $urandom_range(1, 6), 15);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 8)) send_beat(ActTick, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) send_beat(ActByte, 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] shared_code;
    shared_code = 8'($urandom);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_wrong_id();
    test_bad_checksum();
    test_timeout_edges();
    test_large_timeout();
    test_backpressure();
    test_random_traffic(0, 0, 8'h00, 8'hFF, TimeoutWidth'(1), 400);
    test_random_traffic(47, 0, 8'hFF, 8'h00, '1, 400);
    test_random_traffic(0, 47, 8'($urandom), 8'($urandom),
                        TimeoutWidth'($urandom_range(1, 12)), 400);
    // id equal to the marker
    test_random_traffic(35, 35, shared_code, shared_code,
                        TimeoutWidth'($urandom_range(2, 8)), 400);
    wait_results_in();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && frame_reports.size() == 0) begin
      $display("framed_packet_receiver_sum_check_unit_tb: clean");
    end else begin
      $display("framed_packet_receiver_sum_check_unit_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: framed_packet_receiver_sum_check_unit.f
rtl/fprsc_pkg.sv
rtl/framed_packet_receiver_sum_check_unit.sv
tb/framed_packet_receiver_sum_check_unit_tb.sv
